@@ src/point_triangle_edge_distance_max_defines.svh @@
// ---------------------------------------------------------------------------
// Point to triangle edge distance: assertion macros
// Shared property wrappers for the checker.
// ---------------------------------------------------------------------------
`ifndef POINT_TRIANGLE_EDGE_DISTANCE_MAX_DEFINES_SVH
`define POINT_TRIANGLE_EDGE_DISTANCE_MAX_DEFINES_SVH

// Property checked only outside reset.
`define PTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ptd_pkg.sv @@
// ---------------------------------------------------------------------------
// ptd_pkg
// Shared constants and register indexes of the edge distance block.
// ---------------------------------------------------------------------------
package ptd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_BITS       = 33;
    localparam int CFG_IDX_BITS   = 3;
    localparam int NUM_VTX_REGS   = 6;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_A_X = 3'd0,
        CFG_A_Y = 3'd1,
        CFG_B_X = 3'd2,
        CFG_B_Y = 3'd3,
        CFG_C_X = 3'd4,
        CFG_C_Y = 3'd5
    } t_cfg_idx;

endpackage

@@ src/ptd_pt_if.sv @@
// ---------------------------------------------------------------------------
// ptd_pt_if
// Point channel: one query point with a restart flag per transfer.
// ---------------------------------------------------------------------------
interface ptd_pt_if #(
    parameter int COORD_BITS = ptd_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         restart;

    modport source (output valid, point_x, point_y, restart, input ready);
    modport sink   (input valid, point_x, point_y, restart, output ready);
endinterface

@@ src/ptd_res_if.sv @@
// ---------------------------------------------------------------------------
// ptd_res_if
// Result channel: point distance and running maximum per transfer.
// ---------------------------------------------------------------------------
interface ptd_res_if ();
    logic                          valid;
    logic                          ready;
    logic [ptd_pkg::OUT_BITS-1:0]  point_distance;
    logic [ptd_pkg::OUT_BITS-1:0]  max_distance;

    modport source (output valid, point_distance, max_distance, input ready);
    modport sink   (input valid, point_distance, max_distance, output ready);
endinterface

@@ src/ptd_fifo.sv @@
// ---------------------------------------------------------------------------
// ptd_fifo
// Two-entry queue between the edge classifier and the root unit.
// ---------------------------------------------------------------------------
module ptd_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_push;
    logic         w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

@@ src/ptd_front.sv @@
// ---------------------------------------------------------------------------
// ptd_front
// Take a point, find per edge the squared distance, as numerator over squared length when the foot is inside.
// ---------------------------------------------------------------------------
module ptd_front #(
    parameter int COORD_BITS = ptd_pkg::COORD_BITS_DEF,
    parameter int EW         = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    ptd_pt_if.sink                                s_pt,
    input  logic [ptd_pkg::NUM_VTX_REGS-1:0][COORD_BITS-1:0] i_vtx,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [EW-1:0]                         o_data
);
    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int NW  = 4 * DW;
    localparam int EW1 = NW + PW + 1;

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_DIFF = 6'b000010,
        F_MUL  = 6'b000100,
        F_CLS  = 6'b001000,
        F_SQ   = 6'b010000,
        F_PUSH = 6'b100000
    } t_fstate;

    t_fstate r_st;
    logic [COORD_BITS-1:0]    r_px;
    logic [COORD_BITS-1:0]    r_py;
    logic                     r_rst;
    logic signed [DW-1:0]     r_dx [3];
    logic signed [DW-1:0]     r_dy [3];
    logic signed [DW-1:0]     r_wx [3];
    logic signed [DW-1:0]     r_wy [3];
    logic signed [DW-1:0]     r_qx [3];
    logic signed [DW-1:0]     r_qy [3];
    logic signed [PW-1:0]     r_pdd [3];
    logic signed [PW-1:0]     r_pee [3];
    logic signed [PW-1:0]     r_pt1 [3];
    logic signed [PW-1:0]     r_pt2 [3];
    logic signed [PW-1:0]     r_pc1 [3];
    logic signed [PW-1:0]     r_pc2 [3];
    logic signed [PW-1:0]     r_pww [3];
    logic signed [PW-1:0]     r_pvv [3];
    logic signed [PW-1:0]     r_pqq [3];
    logic signed [PW-1:0]     r_prr [3];
    logic                     r_dir [3];
    logic [PW-1:0]            r_den [3];
    logic [PW-1:0]            r_c   [3];
    logic [NW-1:0]            r_num [3];

    function automatic logic signed [DW-1:0] ext(input logic [COORD_BITS-1:0] v);
        ext = $signed({v[COORD_BITS-1], v});
    endfunction

    assign s_pt.ready = (r_st == F_IDLE);
    assign o_valid    = (r_st == F_PUSH);

    always_comb begin
        o_data = '0;
        for (int k = 0; k < 3; k++) begin
            o_data[k*EW1 +: EW1] = {r_dir[k], r_den[k], r_num[k]};
        end
        o_data[EW-1] = r_rst;
    end

    always_ff @(posedge i_clk) begin
        logic signed [PW:0] v_len;
        logic signed [PW:0] v_t;
        logic signed [PW:0] v_cr;
        int                 e;
        unique case (r_st)
            F_IDLE: begin
                r_px  <= s_pt.point_x;
                r_py  <= s_pt.point_y;
                r_rst <= s_pt.restart;
            end
            F_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    e = (k == 2) ? 0 : k + 1;
                    r_dx[k] <= ext(i_vtx[2*e])   - ext(i_vtx[2*k]);
                    r_dy[k] <= ext(i_vtx[2*e+1]) - ext(i_vtx[2*k+1]);
                    r_wx[k] <= ext(r_px) - ext(i_vtx[2*k]);
                    r_wy[k] <= ext(r_py) - ext(i_vtx[2*k+1]);
                    r_qx[k] <= ext(r_px) - ext(i_vtx[2*e]);
                    r_qy[k] <= ext(r_py) - ext(i_vtx[2*e+1]);
                end
            end
            F_MUL: begin
                for (int k = 0; k < 3; k++) begin
                    r_pdd[k] <= r_dx[k] * r_dx[k];
                    r_pee[k] <= r_dy[k] * r_dy[k];
                    r_pt1[k] <= r_wx[k] * r_dx[k];
                    r_pt2[k] <= r_wy[k] * r_dy[k];
                    r_pc1[k] <= r_wx[k] * r_dy[k];
                    r_pc2[k] <= r_wy[k] * r_dx[k];
                    r_pww[k] <= r_wx[k] * r_wx[k];
                    r_pvv[k] <= r_wy[k] * r_wy[k];
                    r_pqq[k] <= r_qx[k] * r_qx[k];
                    r_prr[k] <= r_qy[k] * r_qy[k];
                end
            end
            F_CLS: begin
                for (int k = 0; k < 3; k++) begin
                    v_len = (PW+1)'(r_pdd[k]) + (PW+1)'(r_pee[k]);
                    v_t   = (PW+1)'(r_pt1[k]) + (PW+1)'(r_pt2[k]);
                    v_cr  = (PW+1)'(r_pc1[k]) - (PW+1)'(r_pc2[k]);
                    r_den[k] <= v_len[PW-1:0];
                    // Degenerate edge or projection before the start: start vertex.
                    if (v_len == '0 || v_t <= (PW+1)'(0)) begin
                        r_dir[k] <= 1'b1;
                        r_c[k]   <= PW'(r_pww[k] + r_pvv[k]);
                    end else if (v_t >= v_len) begin
                        r_dir[k] <= 1'b1;
                        r_c[k]   <= PW'(r_pqq[k] + r_prr[k]);
                    end else begin
                        r_dir[k] <= 1'b0;
                        r_c[k]   <= v_cr[PW] ? PW'(-v_cr) : v_cr[PW-1:0];
                    end
                end
            end
            F_SQ: begin
                for (int k = 0; k < 3; k++) begin
                    r_num[k] <= r_dir[k] ? NW'(r_c[k]) : NW'(r_c[k] * r_c[k]);
                end
            end
            F_PUSH: begin
            end
            default: begin
            end
        endcase
        if (!i_rst_n) begin
            r_st <= F_IDLE;
        end else begin
            unique case (r_st)
                F_IDLE:  r_st <= s_pt.valid ? F_DIFF : F_IDLE;
                F_DIFF:  r_st <= F_MUL;
                F_MUL:   r_st <= F_CLS;
                F_CLS:   r_st <= F_SQ;
                F_SQ:    r_st <= F_PUSH;
                F_PUSH:  r_st <= i_ready ? F_IDLE : F_PUSH;
                default: r_st <= F_IDLE;
            endcase
        end
    end
endmodule

@@ src/ptd_back.sv @@
// ---------------------------------------------------------------------------
// ptd_back
// Divide, take the least edge value, round the root, track the maximum.
// ---------------------------------------------------------------------------
module ptd_back #(
    parameter int COORD_BITS = ptd_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ptd_pkg::FRAC_BITS_DEF,
    parameter int EW         = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [EW-1:0] i_data,
    ptd_res_if.source     m_res
);
    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int NW   = 4 * DW;
    localparam int EW1  = NW + PW + 1;
    localparam int SH   = 2 * FRAC_BITS + 2;
    localparam int XW   = NW + SH;
    localparam int RW   = XW / 2;
    localparam int OW   = ptd_pkg::OUT_BITS;
    localparam int CNTW = $clog2(XW + 1);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_EDGE = 6'b000010,
        B_DIV  = 6'b000100,
        B_DEND = 6'b001000,
        B_SQRT = 6'b010000,
        B_FIN  = 6'b100000
    } t_bstate;

    t_bstate         r_st;
    logic [EW-1:0]   r_ent;
    logic [1:0]      r_e;
    logic [CNTW-1:0] r_cnt;
    logic [XW-1:0]   r_x;
    logic [XW-1:0]   r_best;
    logic [PW-1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [RW+1:0]   r_srem;
    logic [OW-1:0]   r_max;
    logic            r_ov;
    logic [OW-1:0]   r_od;
    logic [OW-1:0]   r_om;

    logic [NW-1:0]   w_num;
    logic [PW-1:0]   w_den;
    logic            w_dir;
    logic [PW:0]     w_dtmp;
    logic            w_dge;
    logic [XW-1:0]   w_cand;
    logic [XW-1:0]   w_nb;
    logic [RW+3:0]   w_stmp;
    logic [RW+3:0]   w_trial;
    logic            w_sge;
    logic [RW:0]     w_rr1;
    logic [RW-1:0]   w_rr;
    logic            w_sat;
    logic [OW-1:0]   w_dist;
    logic [OW-1:0]   w_base;
    logic            w_load;

    always_comb begin
        w_num   = r_ent[r_e*EW1 +: NW];
        w_den   = r_ent[r_e*EW1 + NW +: PW];
        w_dir   = r_ent[r_e*EW1 + NW + PW];
        w_dtmp  = {r_rem, r_x[XW-1]};
        w_dge   = (w_dtmp >= {1'b0, w_den});
        w_cand  = (r_st == B_DEND) ? r_x : (XW'(w_num) << SH);
        w_nb    = (w_cand < r_best) ? w_cand : r_best;
        w_stmp  = {r_srem, r_x[XW-1 -: 2]};
        w_trial = (RW+4)'({r_root, 2'b01});
        w_sge   = (w_stmp >= w_trial);
        // Round to nearest: largest odd value not above the root, halved up.
        w_rr1   = ({1'b0, r_root} + (RW+1)'(1)) >> 1;
        w_rr    = w_rr1[RW-1:0];
        w_sat   = (RW > OW) ? |(w_rr >> OW) : 1'b0;
        w_dist  = w_sat ? '1 : OW'(w_rr);
        w_base  = r_ent[EW-1] ? '0 : r_max;
        w_load  = (r_st == B_FIN) && (!r_ov || m_res.ready);
    end

    assign o_ready              = (r_st == B_IDLE);
    assign m_res.valid          = r_ov;
    assign m_res.point_distance = r_od;
    assign m_res.max_distance   = r_om;

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            B_IDLE: begin
                r_ent  <= i_data;
                r_e    <= 2'd0;
                r_best <= '1;
            end
            B_EDGE, B_DEND: begin
                if ((r_st == B_EDGE) && !w_dir) begin
                    r_x   <= XW'(w_num) << SH;
                    r_rem <= '0;
                    r_cnt <= CNTW'(XW);
                end else if (r_e == 2'd2) begin
                    r_x    <= w_nb;
                    r_root <= '0;
                    r_srem <= '0;
                    r_cnt  <= CNTW'(RW);
                end else begin
                    r_best <= w_nb;
                    r_e    <= r_e + 2'd1;
                end
            end
            B_DIV: begin
                r_rem <= w_dge ? PW'(w_dtmp - {1'b0, w_den}) : w_dtmp[PW-1:0];
                r_x   <= {r_x[XW-2:0], w_dge};
                r_cnt <= r_cnt - CNTW'(1);
            end
            B_SQRT: begin
                r_srem <= w_sge ? (RW+2)'(w_stmp - w_trial) : w_stmp[RW+1:0];
                r_root <= {r_root[RW-2:0], w_sge};
                r_x    <= r_x << 2;
                r_cnt  <= r_cnt - CNTW'(1);
            end
            B_FIN: begin
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_od <= w_dist;
            r_om <= (w_dist > w_base) ? w_dist : w_base;
        end
        if (!i_rst_n) begin
            r_st  <= B_IDLE;
            r_ov  <= 1'b0;
            r_max <= '0;
        end else begin
            if (m_res.ready) begin
                r_ov <= 1'b0;
            end
            if (w_load) begin
                r_ov  <= 1'b1;
                r_max <= (w_dist > w_base) ? w_dist : w_base;
            end
            unique case (r_st)
                B_IDLE: r_st <= i_valid ? B_EDGE : B_IDLE;
                B_EDGE: begin
                    if (!w_dir) begin
                        r_st <= B_DIV;
                    end else if (r_e == 2'd2) begin
                        r_st <= B_SQRT;
                    end
                end
                B_DIV:  r_st <= (r_cnt == CNTW'(1)) ? B_DEND : B_DIV;
                B_DEND: r_st <= (r_e == 2'd2) ? B_SQRT : B_EDGE;
                B_SQRT: r_st <= (r_cnt == CNTW'(1)) ? B_FIN : B_SQRT;
                B_FIN:  r_st <= w_load ? B_IDLE : B_FIN;
                default: r_st <= B_IDLE;
            endcase
        end
    end
endmodule

@@ src/point_triangle_edge_distance_max.sv @@
// ---------------------------------------------------------------------------
// point_triangle_edge_distance_max
// Distance from a point to the nearest triangle edge, with running maximum.
// ---------------------------------------------------------------------------
// Usage:
//   Load the three vertices through the write port (index 0..5 = A.x, A.y,
//   B.x, B.y, C.x, C.y) while the block is idle. Send points on s_pt; each
//   transfer yields one transfer on m_res with the rounded distance and the
//   running maximum (FRAC_BITS fraction bits). restart clears the maximum
//   before the point counts.
// Operation:
//   The classifier steps each point through difference, multiply, classify,
//   square and push states. The root unit then runs a one-bit-per-cycle
//   divider for each edge whose foot lies inside it (XW-bit dividend,
//   XW = 4*(COORD_BITS+1) + 2*FRAC_BITS + 2) and a two-bit-per-cycle square
//   root of the least edge value. A two-entry queue lets the classifier take
//   new points meanwhile.
// Reset:
//   Synchronous, active low: vertices and running maximum go to zero, all
//   queues empty. A stalled result holds on m_res while work continues
//   upstream until the queue fills.
// ---------------------------------------------------------------------------
module point_triangle_edge_distance_max #(
    parameter int COORD_BITS = ptd_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ptd_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ptd_pt_if.sink                           s_pt,
    ptd_res_if.source                        m_res,
    input  logic                             i_cfg_we,
    input  logic [ptd_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]            i_cfg_data
);
    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int NW  = 4 * DW;
    localparam int EW  = 3 * (NW + PW + 1) + 1;

    // Vertex registers, one per configuration index.
    logic [ptd_pkg::NUM_VTX_REGS-1:0][COORD_BITS-1:0] r_vtx;

    logic          w_fv;
    logic          w_fr;
    logic [EW-1:0] w_fd;
    logic          w_qv;
    logic          w_qr;
    logic [EW-1:0] w_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx <= '0;
        end else if (i_cfg_we) begin
            // Drop writes beyond the register list.
            unique case (i_cfg_idx)
                ptd_pkg::CFG_A_X: r_vtx[ptd_pkg::CFG_A_X] <= i_cfg_data;
                ptd_pkg::CFG_A_Y: r_vtx[ptd_pkg::CFG_A_Y] <= i_cfg_data;
                ptd_pkg::CFG_B_X: r_vtx[ptd_pkg::CFG_B_X] <= i_cfg_data;
                ptd_pkg::CFG_B_Y: r_vtx[ptd_pkg::CFG_B_Y] <= i_cfg_data;
                ptd_pkg::CFG_C_X: r_vtx[ptd_pkg::CFG_C_X] <= i_cfg_data;
                ptd_pkg::CFG_C_Y: r_vtx[ptd_pkg::CFG_C_Y] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Classify edges: squared distance, as numerator over squared edge length when the foot is inside.
    ptd_front #(
        .COORD_BITS (COORD_BITS),
        .EW         (EW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_pt    (s_pt),
        .i_vtx   (r_vtx),
        .o_valid (w_fv),
        .i_ready (w_fr),
        .o_data  (w_fd)
    );

    // Decouple the classifier from the long-running root unit.
    ptd_fifo #(
        .W (EW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .i_data  (w_fd),
        .o_valid (w_qv),
        .i_ready (w_qr),
        .o_data  (w_qd)
    );

    // Divide, take the least edge, round the root, advance the maximum.
    ptd_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .EW         (EW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qv),
        .o_ready (w_qr),
        .i_data  (w_qd),
        .m_res   (m_res)
    );
endmodule

@@ src/ptd_check.sv @@
// ---------------------------------------------------------------------------
// ptd_check
// Port-level checks of the result channel.
// ---------------------------------------------------------------------------
`include "point_triangle_edge_distance_max_defines.svh"

module ptd_check (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic [ptd_pkg::OUT_BITS-1:0] i_dist,
    input logic [ptd_pkg::OUT_BITS-1:0] i_max
);
    `PTD_ASSERT(a_hold, i_clk, i_rst_n, i_valid && !i_ready |=> i_valid && $stable(i_dist), "stalled result changed")
    `PTD_ASSERT(a_max_ge, i_clk, i_rst_n, i_valid |-> i_max >= i_dist, "maximum below distance")
    `PTD_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !i_valid, "result valid after reset")
endmodule

bind point_triangle_edge_distance_max ptd_check u_ptd_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (m_res.valid),
    .i_ready (m_res.ready),
    .i_dist  (m_res.point_distance),
    .i_max   (m_res.max_distance)
);

@@ tb/sv/ptd_scoreboard.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptd_scoreboard
// Watches the vertex write port and both channels, predicts the distance and
// running maximum of every accepted point, and compares each result transfer.
// ---------------------------------------------------------------------------
module ptd_scoreboard (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ptd_pt_if                                pt,
    ptd_res_if                               res,
    input  logic                             i_cfg_we,
    input  logic [ptd_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [ptd_pkg::COORD_BITS_DEF-1:0] i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    localparam int RSHIFT = 2 * ptd_pkg::FRAC_BITS_DEF + 2;

    typedef struct packed {
        logic [ptd_pkg::OUT_BITS-1:0] pdist;
        logic [ptd_pkg::OUT_BITS-1:0] maxd;
    } t_dist_pair;

    logic signed [ptd_pkg::COORD_BITS_DEF-1:0] vertex [ptd_pkg::NUM_VTX_REGS];
    logic [ptd_pkg::OUT_BITS-1:0]              farthest;
    t_dist_pair                                dist_q [$];

    // Squared distance from a point to one closed segment, as num / den.
    function automatic void edge_sq(input longint px, py, sx, sy, ex, ey,
                                    output logic [127:0] num,
                                    output logic [127:0] den);
        longint dx, dy, wx, wy, len, t, qx, qy, cr;
        logic [127:0] cu;
        dx  = ex - sx;
        dy  = ey - sy;
        wx  = px - sx;
        wy  = py - sy;
        len = dx * dx + dy * dy;
        t   = wx * dx + wy * dy;
        if (len == 0 || t <= 0) begin
            num = 128'(wx * wx + wy * wy);
            den = 1;
        end else if (t >= len) begin
            qx  = px - ex;
            qy  = py - ey;
            num = 128'(qx * qx + qy * qy);
            den = 1;
        end else begin
            cr  = wx * dy - wy * dx;
            if (cr < 0) cr = -cr;
            cu  = 128'(cr);
            num = cu * cu;
            den = 128'(len);
        end
    endfunction

    function automatic logic [ptd_pkg::OUT_BITS-1:0] nearest_edge(input longint px, py);
        logic [127:0] bn, bd, n, d, rhs, odd, lhs, lo, hi, mid;
        longint vx [3];
        longint vy [3];
        int j;
        for (int i = 0; i < 3; i++) begin
            vx[i] = vertex[2*i];
            vy[i] = vertex[2*i+1];
        end
        bn = 0;
        bd = 1;
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            edge_sq(px, py, vx[i], vy[i], vx[j], vy[j], n, d);
            if (i == 0 || n * bd < bn * d) begin
                bn = n;
                bd = d;
            end
        end
        // Largest r with (2r-1)^2 * den <= 4 * num * 4^FRAC_BITS.
        rhs = bn << RSHIFT;
        lo  = 0;
        hi  = 128'd1 << 44;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            odd = 2 * mid - 1;
            lhs = odd * odd * bd;
            if (lhs <= rhs) lo = mid;
            else hi = mid;
        end
        if (lo >= (128'd1 << ptd_pkg::OUT_BITS)) return '1;
        return lo[ptd_pkg::OUT_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_dist_pair got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < ptd_pkg::NUM_VTX_REGS; i++) vertex[i] = '0;
            farthest = '0;
            dist_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we && i_cfg_idx < ptd_pkg::NUM_VTX_REGS) begin
                vertex[i_cfg_idx] = i_cfg_data;
            end
            // Compare the result first: it always belongs to an older point.
            if (res.valid && res.ready) begin
                got.pdist = res.point_distance;
                got.maxd  = res.max_distance;
                if (dist_q.size() == 0) begin
                    $error("result transfer with nothing expected: dist=%0d max=%0d",
                           got.pdist, got.maxd);
                    o_fail_count++;
                end else begin
                    want = dist_q.pop_front();
                    if (got.pdist !== want.pdist) begin
                        $error("point_distance: expected %0d, got %0d",
                               want.pdist, got.pdist);
                        o_fail_count++;
                    end
                    if (got.maxd !== want.maxd) begin
                        $error("max_distance: expected %0d, got %0d", want.maxd, got.maxd);
                        o_fail_count++;
                    end
                end
            end
            if (pt.valid && pt.ready) begin
                want.pdist = nearest_edge(longint'(pt.point_x), longint'(pt.point_y));
                if (pt.restart) farthest = '0;
                if (want.pdist > farthest) farthest = want.pdist;
                want.maxd = farthest;
                dist_q.push_back(want);
            end
        end
        o_pending = dist_q.size();
    end
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives triangles and query points into the edge distance block with random
// gaps on both channels; the scoreboard predicts and checks every result.
// ---------------------------------------------------------------------------
module tb;
    localparam int  CB        = ptd_pkg::COORD_BITS_DEF;
    localparam int  LIMIT     = 3_000_000;
    localparam int  IDLE_PCT  = 21;
    localparam int  DRAIN     = 400;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             cfg_we;
    logic [ptd_pkg::CFG_IDX_BITS-1:0] cfg_idx;
    logic [CB-1:0]                    cfg_data;
    int                               fail_count;
    int                               pending;
    int                               cycle_cnt;
    bit                               no_idle;

    ptd_pt_if #(.COORD_BITS(CB)) pt ();
    ptd_res_if                   res ();

    point_triangle_edge_distance_max #(
        .COORD_BITS (CB),
        .FRAC_BITS  (ptd_pkg::FRAC_BITS_DEF)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_pt       (pt),
        .m_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ptd_scoreboard i_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .pt           (pt),
        .res          (res),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at random, except during the no-idle stretch.
    always @(negedge i_clk) begin
        res.ready = no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [CB-1:0] clip(input int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[CB-1:0];
    endfunction

    // Write one vertex register; the block must be idle.
    task automatic write_reg(input ptd_pkg::t_cfg_idx idx, input logic [CB-1:0] val);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    task automatic load_triangle(input int ax, ay, bx, by, cx, cy);
        write_reg(ptd_pkg::CFG_A_X, clip(ax));
        write_reg(ptd_pkg::CFG_A_Y, clip(ay));
        write_reg(ptd_pkg::CFG_B_X, clip(bx));
        write_reg(ptd_pkg::CFG_B_Y, clip(by));
        write_reg(ptd_pkg::CFG_C_X, clip(cx));
        write_reg(ptd_pkg::CFG_C_Y, clip(cy));
    endtask

    // Offer one point, hold it until the transfer, then advance to the next
    // falling edge. valid stays high so back-to-back points need no bubble.
    task automatic send_point(input int x, y, input bit rst_max);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            pt.valid = 1'b0;
            @(negedge i_clk);
        end
        pt.valid   = 1'b1;
        pt.point_x = clip(x);
        pt.point_y = clip(y);
        pt.restart = rst_max;
        do @(posedge i_clk); while (!(pt.valid && pt.ready));
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected result has arrived, then let
    // the pipeline settle before the vertices change.
    task automatic drain;
        pt.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    function automatic int rnd16();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    initial begin
        int vtx [6];
        int base, px, py, spread;
        cycle_cnt = 0;
        no_idle   = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        pt.valid  = 1'b0;
        pt.point_x = '0;
        pt.point_y = '0;
        pt.restart = 1'b0;
        res.ready = 1'b0;
        i_rst_n   = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n   = 1'b1;

        // Reset triangle: every edge collapses to the origin.
        send_point(0, 0, 1'b0);
        send_point(32767, 32767, 1'b0);
        send_point(-32768, -32768, 1'b0);
        send_point(-32768, 32767, 1'b1);
        send_point(5, -3, 1'b0);
        drain();

        // Largest triangle the coordinates allow.
        load_triangle(-32768, -32768, 32767, -32768, 0, 32767);
        send_point(0, 0, 1'b1);
        send_point(-32768, -32768, 1'b0);
        send_point(32767, 32767, 1'b0);
        send_point(-32768, 32767, 1'b0);
        send_point(0, -32768, 1'b0);
        send_point(32767, -32768, 1'b1);
        send_point(100, -100, 1'b0);
        drain();

        // One zero-length edge: A and B coincide.
        load_triangle(1000, 1000, 1000, 1000, -2000, 3000);
        send_point(1000, 1000, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(-2000, 3000, 1'b0);
        send_point(-32768, 32767, 1'b0);
        send_point(500, 2000, 1'b0);
        drain();

        // Random triangles, each with a burst of points.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: for (int i = 0; i < 6; i++) vtx[i] = rnd16();
                1: begin
                    base = rnd16();
                    for (int i = 0; i < 6; i++) vtx[i] = base + $urandom_range(64) - 32;
                end
                2: begin
                    for (int i = 0; i < 6; i++) vtx[i] = rnd16() / 16;
                    vtx[4] = vtx[2 * ($urandom_range(1))];
                    vtx[5] = vtx[2 * ($urandom_range(1)) + 1];
                end
                default: begin
                    // Collinear vertices.
                    vtx[0] = rnd16() / 4; vtx[1] = rnd16() / 4;
                    vtx[2] = rnd16() / 4; vtx[3] = rnd16() / 4;
                    vtx[4] = 2 * vtx[2] - vtx[0];
                    vtx[5] = 2 * vtx[3] - vtx[1];
                end
            endcase
            load_triangle(vtx[0], vtx[1], vtx[2], vtx[3], vtx[4], vtx[5]);
            no_idle = (ph == 5);
            for (int n = 0; n < 50; n++) begin
                if ($urandom_range(99) < 60) begin
                    base   = 2 * $urandom_range(2);
                    spread = ($urandom_range(1)) ? 40 : 4000;
                    px = vtx[base] + $urandom_range(2 * spread) - spread;
                    py = vtx[base + 1] + $urandom_range(2 * spread) - spread;
                end else begin
                    px = rnd16();
                    py = rnd16();
                end
                send_point(px, py, $urandom_range(99) < 10);
            end
            no_idle = 1'b0;
            drain();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
